[rtl/rfit_pkg.sv]
`timescale 1ns / 1ps
package rfit_pkg;

    localparam int SYM_W  = 8;
    localparam int FREQ_W = 16;
    localparam int EDGE_W = 24;
    localparam int USED_W = 9;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_RANK   = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_CLR, IDX_INC, IDX_DEC, IDX_TOTAL
    } t_idx_op;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_CLR, ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        RD_NONE, RD_IDX, RD_NEXT, RD_PREV
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE, WR_SHIFT, WR_NEW
    } t_wr_sel;

    typedef enum logic [1:0] {
        TOT_HOLD, TOT_CLR, TOT_INC, TOT_DEC
    } t_tot_op;

    typedef enum logic [1:0] {
        EMIT_NONE, EMIT_MISS, EMIT_RD, EMIT_NEW
    } t_emit;

    typedef struct packed {
        logic    latch;
        t_idx_op idx_op;
        t_acc_op acc_op;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_tot_op tot_op;
        logic    pos_cap;
        t_emit   emit;
    } t_cmd;

    typedef struct packed {
        logic idx_eq_total;
        logic next_eq_total;
        logic idx_eq_pos;
        logic full;
        logic sym_hit;
        logic rank_hit;
        logic before_new;
    } t_stat;

endpackage

[rtl/rfit_ctrl.sv]
`timescale 1ns / 1ps
module rfit_ctrl import rfit_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  [1:0] i_req_type,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DEL_RD, S_DEL_EV, S_INS_RD, S_INS_EV,
        S_UP_RD, S_UP_EV, S_DONE_MISS, S_DONE_RD, S_DONE_NEW
    } t_state;

    t_state r_state, n_state;
    t_req   r_req, n_req;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        o_cmd   = '{latch: 1'b0, idx_op: IDX_HOLD, acc_op: ACC_HOLD, rd_sel: RD_NONE,
                    wr_sel: WR_NONE, tot_op: TOT_HOLD, pos_cap: 1'b0, emit: EMIT_NONE};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req        = t_req'(i_req_type);
                    o_cmd.latch  = 1'b1;
                    o_cmd.idx_op = IDX_CLR;
                    o_cmd.acc_op = ACC_CLR;
                    if (t_req'(i_req_type) == REQ_CLEAR) begin
                        o_cmd.tot_op = TOT_CLR;
                        n_state      = S_DONE_MISS;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (i_stat.idx_eq_total) begin
                    if (r_req == REQ_LOAD) begin
                        o_cmd.idx_op = IDX_CLR;
                        o_cmd.acc_op = ACC_CLR;
                        n_state      = S_INS_RD;
                    end else begin
                        n_state = S_DONE_MISS;
                    end
                end else begin
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if ((r_req == REQ_RANK) ? i_stat.rank_hit : i_stat.sym_hit) begin
                    n_state = (r_req == REQ_LOAD) ? S_DEL_RD : S_DONE_RD;
                end else begin
                    o_cmd.acc_op = ACC_ADD;
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_SCAN_RD;
                end
            end
            S_DEL_RD: begin
                if (i_stat.next_eq_total) begin
                    o_cmd.tot_op = TOT_DEC;
                    o_cmd.idx_op = IDX_CLR;
                    o_cmd.acc_op = ACC_CLR;
                    n_state      = S_INS_RD;
                end else begin
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DEL_EV;
                end
            end
            S_DEL_EV: begin
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_DEL_RD;
            end
            S_INS_RD: begin
                if (i_stat.full) begin
                    n_state = S_DONE_MISS;
                end else if (i_stat.idx_eq_total) begin
                    o_cmd.pos_cap = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_INS_EV;
                end
            end
            S_INS_EV: begin
                if (i_stat.before_new) begin
                    o_cmd.acc_op = ACC_ADD;
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_INS_RD;
                end else begin
                    o_cmd.pos_cap = 1'b1;
                    o_cmd.idx_op  = IDX_TOTAL;
                    n_state       = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (i_stat.idx_eq_pos) begin
                    o_cmd.wr_sel = WR_NEW;
                    o_cmd.tot_op = TOT_INC;
                    n_state      = S_DONE_NEW;
                end else begin
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_UP_EV;
                end
            end
            S_UP_EV: begin
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_UP_RD;
            end
            S_DONE_MISS: begin
                o_cmd.emit = EMIT_MISS;
                n_state    = S_IDLE;
            end
            S_DONE_RD: begin
                o_cmd.emit = EMIT_RD;
                n_state    = S_IDLE;
            end
            S_DONE_NEW: begin
                o_cmd.emit = EMIT_NEW;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_CLEAR;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

endmodule

[rtl/rfit_dpath.sv]
`timescale 1ns / 1ps
module rfit_dpath import rfit_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_freq,
    input  logic [7:0]        i_rank,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic              o_found,
    output logic [7:0]        o_out_rank,
    output logic [SYM_W-1:0]  o_out_symbol,
    output logic [FREQ_W-1:0] o_out_freq,
    output logic [EDGE_W-1:0] o_left_edge,
    output logic [EDGE_W-1:0] o_right_edge,
    output logic [USED_W-1:0] o_entries_used
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = SYM_W + FREQ_W;

    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rdata;
    logic [IW-1:0] r_idx, r_pos, r_total;
    logic [EDGE_W-1:0] r_acc;
    logic [SYM_W-1:0]  r_sym;
    logic [FREQ_W-1:0] r_freq;
    logic [7:0]        r_rank;
    logic [IW-1:0]     idx_next, idx_prev;
    logic [AW-1:0]     rd_addr;
    logic [SYM_W-1:0]  rd_sym;
    logic [FREQ_W-1:0] rd_freq;

    assign idx_next = r_idx + IW'(1);
    assign idx_prev = r_idx - IW'(1);
    assign rd_sym   = r_rdata[EW-1:FREQ_W];
    assign rd_freq  = r_rdata[FREQ_W-1:0];

    always_comb begin
        case (i_cmd.rd_sel)
            RD_NEXT: rd_addr = idx_next[AW-1:0];
            RD_PREV: rd_addr = idx_prev[AW-1:0];
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    // status; ties broken on symbol as a signed byte
    always_comb begin
        o_stat.idx_eq_total  = (r_idx == r_total);
        o_stat.next_eq_total = (idx_next == r_total);
        o_stat.idx_eq_pos    = (r_idx == r_pos);
        o_stat.full          = (r_total == IW'(TABLE_DEPTH));
        o_stat.sym_hit       = (rd_sym == r_sym);
        o_stat.rank_hit      = (USED_W'(r_idx) == USED_W'(r_rank));
        o_stat.before_new    = (rd_freq > r_freq) ||
                               ((rd_freq == r_freq) &&
                                ((rd_sym ^ 8'h80) < (r_sym ^ 8'h80)));
    end

    // table store
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel != RD_NONE) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.wr_sel == WR_SHIFT) begin
            r_mem[r_idx[AW-1:0]] <= r_rdata;
        end else if (i_cmd.wr_sel == WR_NEW) begin
            r_mem[r_idx[AW-1:0]] <= {r_sym, r_freq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sym  <= i_symbol;
            r_freq <= i_freq;
            r_rank <= i_rank;
        end
        if (i_cmd.pos_cap) begin
            r_pos <= r_idx;
        end
        case (i_cmd.idx_op)
            IDX_CLR:   r_idx <= '0;
            IDX_INC:   r_idx <= idx_next;
            IDX_DEC:   r_idx <= idx_prev;
            IDX_TOTAL: r_idx <= r_total;
            default:   r_idx <= r_idx;
        endcase
        case (i_cmd.acc_op)
            ACC_CLR: r_acc <= '0;
            ACC_ADD: r_acc <= r_acc + EDGE_W'(rd_freq);
            default: r_acc <= r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            o_valid <= 1'b0;
        end else begin
            case (i_cmd.tot_op)
                TOT_CLR: r_total <= '0;
                TOT_INC: r_total <= r_total + IW'(1);
                TOT_DEC: r_total <= r_total - IW'(1);
                default: r_total <= r_total;
            endcase
            o_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EMIT_NONE) begin
            o_entries_used <= USED_W'(r_total);
            case (i_cmd.emit)
                EMIT_RD: begin
                    o_found      <= 1'b1;
                    o_out_rank   <= 8'(r_idx);
                    o_out_symbol <= rd_sym;
                    o_out_freq   <= rd_freq;
                    o_left_edge  <= r_acc;
                    o_right_edge <= r_acc + EDGE_W'(rd_freq);
                end
                EMIT_NEW: begin
                    o_found      <= 1'b1;
                    o_out_rank   <= 8'(r_idx);
                    o_out_symbol <= r_sym;
                    o_out_freq   <= r_freq;
                    o_left_edge  <= r_acc;
                    o_right_edge <= r_acc + EDGE_W'(r_freq);
                end
                default: begin
                    o_found      <= 1'b0;
                    o_out_rank   <= '0;
                    o_out_symbol <= '0;
                    o_out_freq   <= '0;
                    o_left_edge  <= '0;
                    o_right_edge <= '0;
                end
            endcase
        end
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= IW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_left_edge == '0 && o_right_edge == '0))
        else $error("miss beat carries an interval");

    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_right_edge == o_left_edge + EDGE_W'(o_out_freq)))
        else $error("right edge does not match left edge plus count");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel != WR_NONE) |-> (r_idx < IW'(TABLE_DEPTH)))
        else $error("table write out of range");

endmodule

[rtl/ranked_frequency_interval_table.sv]
`timescale 1ns / 1ps
// Ranked symbol-frequency table for an arithmetic coder. Raise start with a
// request while busy is low; the block takes it at that edge, holds busy high
// while it works and then gives one result beat, o_valid high for exactly one
// cycle. The receiver cannot stall, so the beat must be taken when shown.
// Entries sit in a single-port table in descending count order (ties by
// symbol as a signed byte); each step reads one entry with a registered read
// and then acts on it. Read by rank and lookup scan up from rank 0 to the
// entry they seek or the end; a load can scan, close the gap left by the old
// entry, find the new place and open a gap. Interval edges are prefix sums
// gathered during the scans. There is no clearing pass after reset: the
// table starts empty.
module ranked_frequency_interval_table import rfit_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_freq,
    input  logic [7:0]        i_rank,
    output logic              o_valid,
    output logic              o_found,
    output logic [7:0]        o_out_rank,
    output logic [SYM_W-1:0]  o_out_symbol,
    output logic [FREQ_W-1:0] o_out_freq,
    output logic [EDGE_W-1:0] o_left_edge,
    output logic [EDGE_W-1:0] o_right_edge,
    output logic [USED_W-1:0] o_entries_used
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: scan, shift-down, insert-scan and shift-up passes
    rfit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // table store, index and prefix-sum registers, result beat
    rfit_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_symbol       (i_symbol),
        .i_freq         (i_freq),
        .i_rank         (i_rank),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_out_rank     (o_out_rank),
        .o_out_symbol   (o_out_symbol),
        .o_out_freq     (o_out_freq),
        .o_left_edge    (o_left_edge),
        .o_right_edge   (o_right_edge),
        .o_entries_used (o_entries_used)
    );

endmodule
